FILE: design/lav_pkg.sv
package lav_pkg;

    localparam int CoordW   = 32;
    localparam int FracBits = 30;
    localparam int AccW     = 67;
    localparam int RndW     = AccW - FracBits;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [CoordW:0]   diff_t;
    typedef logic signed [CoordW:0]   uvec_t;
    typedef logic signed [AccW-1:0]   acc_t;
    typedef logic signed [RndW-1:0]   rnd_t;
    typedef logic [1:0]               row_t;

    localparam row_t RowSide  = 2'd0;
    localparam row_t RowUp    = 2'd1;
    localparam row_t RowFwd   = 2'd2;
    localparam row_t RowConst = 2'd3;

    localparam coord_t Q16One = 32'sh0001_0000;

    // round half away from zero, drop the fraction
    function automatic rnd_t rnd_q30(input acc_t v);
        acc_t t;
        t = v + (v[AccW-1] ? acc_t'((64'd1 << (FracBits - 1)) - 64'd1)
                           : acc_t'(64'd1 << (FracBits - 1)));
        return rnd_t'(t[AccW-1:FracBits]);
    endfunction

    function automatic coord_t sat32(input rnd_t v);
        if (v > rnd_t'(32'sh7fff_ffff)) begin
            return 32'sh7fff_ffff;
        end else if (v < rnd_t'(32'sh8000_0000)) begin
            return 32'sh8000_0000;
        end else begin
            return coord_t'(v[CoordW-1:0]);
        end
    endfunction

endpackage

FILE: design/look_at_view_matrix.sv
// Channel  Ports                               Moves
// -------  ----------------------------------  -----------------------------------
// s_       s_valid s_ready s_eye_* s_target_*  one item: eye and target, Q16.16
// m_       m_valid m_ready m_row_index m_col_* four items per input: matrix rows
//          m_degenerate m_last_row
//
// Fully pipelined, 145 register stages from input to the first row; one row leaves
// per cycle while m_ready is high. Each item occupies the output register for its
// four rows, and a new item enters only as the last of them is taken; the pipeline
// holds as a whole while the output register is still busy. Depth is set by the two
// normalisers, 69 stages each, mostly a 31-step square root and a 31-step divide.
// aresetn is synchronous, active low, and clears only the valid bits and the row index.
module look_at_view_matrix
    import lav_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  coord_t s_eye_x,
    input  coord_t s_eye_y,
    input  coord_t s_eye_z,
    input  coord_t s_target_x,
    input  coord_t s_target_y,
    input  coord_t s_target_z,
    output logic   m_valid,
    input  logic   m_ready,
    output row_t   m_row_index,
    output coord_t m_col_a,
    output coord_t m_col_b,
    output coord_t m_col_c,
    output coord_t m_col_d,
    output logic   m_degenerate,
    output logic   m_last_row
);

    localparam int N1SideW = 3 * CoordW;
    localparam int N2SideW = 6 * CoordW + 1;
    localparam int PostW   = 5;

    logic en;

    logic   t0_vld_reg;
    diff_t  t0_d_reg [3];
    coord_t t0_eye_reg [3];

    logic               n1_vld;
    coord_t             n1_f [3];
    logic               n1_zero;
    logic [N1SideW-1:0] n1_side;
    diff_t              n2_in [3];
    logic               n2_vld;
    coord_t             n2_s [3];
    logic               n2_zero;
    logic [N2SideW-1:0] n2_side;
    coord_t             n2_eye [3];
    coord_t             n2_f [3];

    logic [PostW-1:0] p_vld_reg;

    logic signed [2*CoordW-1:0] p1_pa_reg, p1_pb_reg, p1_pc_reg, p1_pd_reg;
    logic signed [2*CoordW-1:0] p1_ps_reg [3];
    logic signed [2*CoordW-1:0] p1_pf_reg [3];
    coord_t p1_s_reg [3];
    coord_t p1_f_reg [3];
    coord_t p1_eye_reg [3];
    logic   p1_degen_reg;

    uvec_t  p2_u_reg [3];
    uvec_t  p2_u_next [3];
    acc_t   p2_accs_reg, p2_accf_reg;
    coord_t p2_s_reg [3];
    coord_t p2_f_reg [3];
    coord_t p2_eye_reg [3];
    logic   p2_degen_reg;

    logic signed [2*CoordW:0] p3_pu_reg [3];
    coord_t p3_ts_reg, p3_tf_reg;
    uvec_t  p3_u_reg [3];
    coord_t p3_s_reg [3];
    coord_t p3_f_reg [3];
    logic   p3_degen_reg;

    acc_t   p4_accu_reg;
    coord_t p4_ts_reg, p4_tf_reg;
    uvec_t  p4_u_reg [3];
    coord_t p4_s_reg [3];
    coord_t p4_f_reg [3];
    logic   p4_degen_reg;

    coord_t p5_tu_reg, p5_ts_reg, p5_tf_reg;
    uvec_t  p5_u_reg [3];
    coord_t p5_s_reg [3];
    coord_t p5_f_reg [3];
    logic   p5_degen_reg;

    logic   o_vld_reg;
    row_t   o_row_reg;
    logic   o_degen_reg;
    coord_t o_s_reg [3];
    coord_t o_u_reg [3];
    coord_t o_nf_reg [3];
    coord_t o_ts_reg, o_tu_reg, o_tf_reg;

    assign en      = !o_vld_reg || (m_ready && o_row_reg == RowConst);
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t0_vld_reg <= 1'b0;
        end else if (en) begin
            t0_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t0_d_reg[0]   <= diff_t'(s_target_x) - diff_t'(s_eye_x);
            t0_d_reg[1]   <= diff_t'(s_target_y) - diff_t'(s_eye_y);
            t0_d_reg[2]   <= diff_t'(s_target_z) - diff_t'(s_eye_z);
            t0_eye_reg[0] <= s_eye_x;
            t0_eye_reg[1] <= s_eye_y;
            t0_eye_reg[2] <= s_eye_z;
        end
    end

    lav_norm #(
        .SideW (N1SideW)
    ) u_norm_fwd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (t0_vld_reg),
        .in_vec    (t0_d_reg),
        .in_side   ({t0_eye_reg[0], t0_eye_reg[1], t0_eye_reg[2]}),
        .out_valid (n1_vld),
        .out_vec   (n1_f),
        .out_zero  (n1_zero),
        .out_side  (n1_side)
    );

    assign n2_in[0] = diff_t'(n1_f[1]);
    assign n2_in[1] = -diff_t'(n1_f[0]);
    assign n2_in[2] = '0;

    lav_norm #(
        .SideW (N2SideW)
    ) u_norm_side (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (n1_vld),
        .in_vec    (n2_in),
        .in_side   ({n1_side, n1_f[0], n1_f[1], n1_f[2], n1_zero}),
        .out_valid (n2_vld),
        .out_vec   (n2_s),
        .out_zero  (n2_zero),
        .out_side  (n2_side)
    );

    assign n2_eye[0] = n2_side[N2SideW-1 -: CoordW];
    assign n2_eye[1] = n2_side[N2SideW-1-CoordW -: CoordW];
    assign n2_eye[2] = n2_side[N2SideW-1-2*CoordW -: CoordW];
    assign n2_f[0]   = n2_side[3*CoordW -: CoordW];
    assign n2_f[1]   = n2_side[2*CoordW -: CoordW];
    assign n2_f[2]   = n2_side[CoordW -: CoordW];

    always_comb begin
        p2_u_next[0] = uvec_t'(rnd_q30(acc_t'(p1_pa_reg)));
        p2_u_next[1] = uvec_t'(rnd_q30(-acc_t'(p1_pb_reg)));
        p2_u_next[2] = uvec_t'(rnd_q30(acc_t'(p1_pc_reg) - acc_t'(p1_pd_reg)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= '0;
        end else if (en) begin
            p_vld_reg <= {p_vld_reg[PostW-2:0], n2_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_pa_reg    <= n2_s[1] * n2_f[2];
            p1_pb_reg    <= n2_s[0] * n2_f[2];
            p1_pc_reg    <= n2_s[0] * n2_f[1];
            p1_pd_reg    <= n2_s[1] * n2_f[0];
            for (int i = 0; i < 3; i++) begin
                p1_ps_reg[i] <= n2_s[i] * n2_eye[i];
                p1_pf_reg[i] <= n2_f[i] * n2_eye[i];
            end
            p1_s_reg     <= n2_s;
            p1_f_reg     <= n2_f;
            p1_eye_reg   <= n2_eye;
            p1_degen_reg <= n2_side[0] || n2_zero;

            p2_u_reg     <= p2_u_next;
            p2_accs_reg  <= acc_t'(p1_ps_reg[0]) + acc_t'(p1_ps_reg[1]) + acc_t'(p1_ps_reg[2]);
            p2_accf_reg  <= acc_t'(p1_pf_reg[0]) + acc_t'(p1_pf_reg[1]) + acc_t'(p1_pf_reg[2]);
            p2_s_reg     <= p1_s_reg;
            p2_f_reg     <= p1_f_reg;
            p2_eye_reg   <= p1_eye_reg;
            p2_degen_reg <= p1_degen_reg;

            for (int i = 0; i < 3; i++) begin
                p3_pu_reg[i] <= p2_u_reg[i] * p2_eye_reg[i];
            end
            p3_ts_reg    <= sat32(-rnd_q30(p2_accs_reg));
            p3_tf_reg    <= sat32(rnd_q30(p2_accf_reg));
            p3_u_reg     <= p2_u_reg;
            p3_s_reg     <= p2_s_reg;
            p3_f_reg     <= p2_f_reg;
            p3_degen_reg <= p2_degen_reg;

            p4_accu_reg  <= acc_t'(p3_pu_reg[0]) + acc_t'(p3_pu_reg[1]) + acc_t'(p3_pu_reg[2]);
            p4_ts_reg    <= p3_ts_reg;
            p4_tf_reg    <= p3_tf_reg;
            p4_u_reg     <= p3_u_reg;
            p4_s_reg     <= p3_s_reg;
            p4_f_reg     <= p3_f_reg;
            p4_degen_reg <= p3_degen_reg;

            p5_tu_reg    <= sat32(-rnd_q30(p4_accu_reg));
            p5_ts_reg    <= p4_ts_reg;
            p5_tf_reg    <= p4_tf_reg;
            p5_u_reg     <= p4_u_reg;
            p5_s_reg     <= p4_s_reg;
            p5_f_reg     <= p4_f_reg;
            p5_degen_reg <= p4_degen_reg;

            o_degen_reg  <= p5_degen_reg;
            o_s_reg      <= p5_s_reg;
            for (int i = 0; i < 3; i++) begin
                o_u_reg[i]  <= coord_t'(p5_u_reg[i][CoordW-1:0]);
                o_nf_reg[i] <= -p5_f_reg[i];
            end
            o_ts_reg     <= p5_ts_reg;
            o_tu_reg     <= p5_tu_reg;
            o_tf_reg     <= p5_tf_reg;
        end
    end

    // hold the item for four rows, advance one row per accepted output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
            o_row_reg <= RowSide;
        end else if (en) begin
            o_vld_reg <= p_vld_reg[PostW-1];
            o_row_reg <= RowSide;
        end else if (m_ready) begin
            o_row_reg <= o_row_reg + 2'd1;
        end
    end

    always_comb begin
        m_col_a = '0;
        m_col_b = '0;
        m_col_c = '0;
        m_col_d = '0;
        if (!o_degen_reg) begin
            case (o_row_reg)
                RowSide: begin
                    m_col_a = o_s_reg[0];
                    m_col_b = o_s_reg[1];
                    m_col_c = o_s_reg[2];
                    m_col_d = o_ts_reg;
                end
                RowUp: begin
                    m_col_a = o_u_reg[0];
                    m_col_b = o_u_reg[1];
                    m_col_c = o_u_reg[2];
                    m_col_d = o_tu_reg;
                end
                RowFwd: begin
                    m_col_a = o_nf_reg[0];
                    m_col_b = o_nf_reg[1];
                    m_col_c = o_nf_reg[2];
                    m_col_d = o_tf_reg;
                end
                default: begin
                    m_col_d = Q16One;
                end
            endcase
        end
    end

    assign m_valid      = o_vld_reg;
    assign m_row_index  = o_row_reg;
    assign m_degenerate = o_degen_reg;
    assign m_last_row   = o_row_reg == RowConst;

`ifndef ASSERT_OFF
    a_row_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_row
        |=> m_valid && m_row_index == 2'($past(m_row_index) + 2'd1))
        else $error("row sequence broken");

    a_degen_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_row |=> m_degenerate == $past(m_degenerate))
        else $error("degenerate flag changed within an item");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no row waiting");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate
        |-> m_col_a == '0 && m_col_b == '0 && m_col_c == '0 && m_col_d == '0)
        else $error("degenerate row not zero");

    a_const_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_row && !m_degenerate
        |-> m_col_a == '0 && m_col_b == '0 && m_col_c == '0 && m_col_d == Q16One)
        else $error("constant row wrong");
`endif

endmodule

FILE: design/lav_norm.sv
module lav_norm
    import lav_pkg::*;
#(
    parameter int SideW = 96
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  diff_t            in_vec [3],
    input  logic [SideW-1:0] in_side,
    output logic             out_valid,
    output coord_t           out_vec [3],
    output logic             out_zero,
    output logic [SideW-1:0] out_side
);

    localparam int MagW      = FracBits;
    localparam int RadW      = 2 * MagW + 2;
    localparam int SqSteps   = RadW / 2;
    localparam int RootW     = SqSteps;
    localparam int RemW      = RootW + 1;
    localparam int QW        = MagW + 1;
    localparam int NumW      = MagW + FracBits + 1;
    localparam int NumStages = 4 + (SqSteps + 1) + (QW + 1) + 1;

    typedef struct packed {
        logic [SideW-1:0]         side;
        logic [2:0]               neg;
        logic                     zero;
        logic [2:0][MagW-1:0]     mag;
    } carry_t;

    logic [NumStages-1:0] vld_reg;

    logic [CoordW-1:0] a_mag_reg [3];
    logic [CoordW-1:0] a_mag_next [3];
    logic [CoordW-1:0] a_max_reg, a_max_next;
    logic [2:0]        a_neg_reg, a_neg_next;
    logic [SideW-1:0]  a_side_reg;

    logic [4:0]        b_sh_reg, b_sh_next;
    logic              b_right_reg, b_right_next;
    logic              b_zero_reg, b_zero_next;
    logic [CoordW-1:0] b_mag_reg [3];
    logic [2:0]        b_neg_reg;
    logic [SideW-1:0]  b_side_reg;

    carry_t            c_carry_reg, c_carry_next;

    logic [2*MagW-1:0] d_sq_reg [3];
    logic [2*MagW-1:0] d_sq_next [3];
    carry_t            d_carry_reg;

    logic [RootW-1:0]  rt_root_reg  [SqSteps+1];
    logic [RootW-1:0]  rt_root_next [SqSteps+1];
    logic [RemW-1:0]   rt_rem_reg   [SqSteps+1];
    logic [RemW-1:0]   rt_rem_next  [SqSteps+1];
    logic [RadW-1:0]   rt_rad_reg   [SqSteps+1];
    logic [RadW-1:0]   rt_rad_next  [SqSteps+1];
    carry_t            rt_carry_reg  [SqSteps+1];
    carry_t            rt_carry_next [SqSteps+1];

    logic [QW-1:0]     dv_rem_reg  [QW+1][3];
    logic [QW-1:0]     dv_rem_next [QW+1][3];
    logic [QW-1:0]     dv_lo_reg   [QW+1][3];
    logic [QW-1:0]     dv_lo_next  [QW+1][3];
    logic [QW-1:0]     dv_q_reg    [QW+1][3];
    logic [QW-1:0]     dv_q_next   [QW+1][3];
    logic [RootW-1:0]  dv_den_reg  [QW+1];
    logic [RootW-1:0]  dv_den_next [QW+1];
    carry_t            dv_carry_reg  [QW+1];
    carry_t            dv_carry_next [QW+1];

    coord_t            g_vec_reg [3];
    coord_t            g_vec_next [3];
    logic              g_zero_reg;
    logic [SideW-1:0]  g_side_reg;

    always_comb begin : mag_find
        diff_t absv;
        for (int i = 0; i < 3; i++) begin
            absv          = in_vec[i][CoordW] ? -in_vec[i] : in_vec[i];
            a_neg_next[i] = in_vec[i][CoordW];
            a_mag_next[i] = absv[CoordW-1:0];
        end
        a_max_next = a_mag_next[0];
        if (a_mag_next[1] > a_max_next) begin
            a_max_next = a_mag_next[1];
        end
        if (a_mag_next[2] > a_max_next) begin
            a_max_next = a_mag_next[2];
        end
    end

    always_comb begin : shift_find
        logic [4:0] msb;
        msb = '0;
        for (int i = 0; i < CoordW; i++) begin
            if (a_max_reg[i]) begin
                msb = 5'(i);
            end
        end
        b_zero_next  = a_max_reg == '0;
        b_right_next = msb > 5'(MagW - 1);
        b_sh_next    = b_right_next ? msb - 5'(MagW - 1) : 5'(MagW - 1) - msb;
    end

    always_comb begin : scale
        logic [CoordW-1:0] sh;
        c_carry_next.side = b_side_reg;
        c_carry_next.neg  = b_neg_reg;
        c_carry_next.zero = b_zero_reg;
        for (int i = 0; i < 3; i++) begin
            sh = b_right_reg ? b_mag_reg[i] >> b_sh_reg : b_mag_reg[i] << b_sh_reg;
            c_carry_next.mag[i] = sh[MagW-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_sq_next[i] = (2 * MagW)'(c_carry_reg.mag[i]) * (2 * MagW)'(c_carry_reg.mag[i]);
        end
    end

    always_comb begin : sqrt_step
        logic [RemW+1:0] rem_sh;
        logic [RemW+1:0] trial;
        rt_root_next[0]  = '0;
        rt_rem_next[0]   = '0;
        rt_rad_next[0]   = RadW'(d_sq_reg[0]) + RadW'(d_sq_reg[1]) + RadW'(d_sq_reg[2]);
        rt_carry_next[0] = d_carry_reg;
        for (int k = 1; k <= SqSteps; k++) begin
            rem_sh = {rt_rem_reg[k-1], rt_rad_reg[k-1][RadW-1:RadW-2]};
            trial  = (RemW + 2)'({rt_root_reg[k-1], 2'b01});
            if (rem_sh >= trial) begin
                rt_rem_next[k]  = RemW'(rem_sh - trial);
                rt_root_next[k] = {rt_root_reg[k-1][RootW-2:0], 1'b1};
            end else begin
                rt_rem_next[k]  = rem_sh[RemW-1:0];
                rt_root_next[k] = {rt_root_reg[k-1][RootW-2:0], 1'b0};
            end
            rt_rad_next[k]   = {rt_rad_reg[k-1][RadW-3:0], 2'b00};
            rt_carry_next[k] = rt_carry_reg[k-1];
        end
    end

    always_comb begin : div_step
        logic [NumW-1:0] num;
        logic [QW:0]     rs;
        dv_den_next[0]   = rt_root_reg[SqSteps];
        dv_carry_next[0] = rt_carry_reg[SqSteps];
        for (int i = 0; i < 3; i++) begin
            num = {1'b0, rt_carry_reg[SqSteps].mag[i], {FracBits{1'b0}}}
                + NumW'(rt_root_reg[SqSteps] >> 1);
            dv_rem_next[0][i] = QW'(num[NumW-1:QW]);
            dv_lo_next[0][i]  = num[QW-1:0];
            dv_q_next[0][i]   = '0;
        end
        for (int k = 1; k <= QW; k++) begin
            dv_den_next[k]   = dv_den_reg[k-1];
            dv_carry_next[k] = dv_carry_reg[k-1];
            for (int i = 0; i < 3; i++) begin
                rs = {dv_rem_reg[k-1][i], dv_lo_reg[k-1][i][QW-1]};
                if (rs >= (QW + 1)'(dv_den_reg[k-1])) begin
                    dv_rem_next[k][i] = QW'(rs - (QW + 1)'(dv_den_reg[k-1]));
                    dv_q_next[k][i]   = {dv_q_reg[k-1][i][QW-2:0], 1'b1};
                end else begin
                    dv_rem_next[k][i] = rs[QW-1:0];
                    dv_q_next[k][i]   = {dv_q_reg[k-1][i][QW-2:0], 1'b0};
                end
                dv_lo_next[k][i] = {dv_lo_reg[k-1][i][QW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            g_vec_next[i] = dv_carry_reg[QW].neg[i] ? -coord_t'(dv_q_reg[QW][i])
                                                     : coord_t'(dv_q_reg[QW][i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NumStages-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_mag_reg     <= a_mag_next;
            a_max_reg     <= a_max_next;
            a_neg_reg     <= a_neg_next;
            a_side_reg    <= in_side;
            b_sh_reg      <= b_sh_next;
            b_right_reg   <= b_right_next;
            b_zero_reg    <= b_zero_next;
            b_mag_reg     <= a_mag_reg;
            b_neg_reg     <= a_neg_reg;
            b_side_reg    <= a_side_reg;
            c_carry_reg   <= c_carry_next;
            d_sq_reg      <= d_sq_next;
            d_carry_reg   <= c_carry_reg;
            rt_root_reg   <= rt_root_next;
            rt_rem_reg    <= rt_rem_next;
            rt_rad_reg    <= rt_rad_next;
            rt_carry_reg  <= rt_carry_next;
            dv_rem_reg    <= dv_rem_next;
            dv_lo_reg     <= dv_lo_next;
            dv_q_reg      <= dv_q_next;
            dv_den_reg    <= dv_den_next;
            dv_carry_reg  <= dv_carry_next;
            g_vec_reg     <= g_vec_next;
            g_zero_reg    <= dv_carry_reg[QW].zero;
            g_side_reg    <= dv_carry_reg[QW].side;
        end
    end

    assign out_valid = vld_reg[NumStages-1];
    assign out_vec   = g_vec_reg;
    assign out_zero  = g_zero_reg;
    assign out_side  = g_side_reg;

endmodule

FILE: verif/lav_checker.sv
`timescale 1ns / 100ps

module lav_checker
    import lav_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    input  logic   s_ready,
    input  coord_t s_eye_x,
    input  coord_t s_eye_y,
    input  coord_t s_eye_z,
    input  coord_t s_target_x,
    input  coord_t s_target_y,
    input  coord_t s_target_z,
    input  logic   m_valid,
    input  logic   m_ready,
    input  row_t   m_row_index,
    input  coord_t m_col_a,
    input  coord_t m_col_b,
    input  coord_t m_col_c,
    input  coord_t m_col_d,
    input  logic   m_degenerate,
    input  logic   m_last_row,
    output int     mismatches,
    output int     rows_pending
);

    typedef logic signed [69:0] wide_t;

    typedef struct packed {
        row_t   idx;
        coord_t a;
        coord_t b;
        coord_t c;
        coord_t d;
        logic   degen;
        logic   last;
    } view_row_t;

    view_row_t rows_due[$];

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit unit_vec(input longint v [3], output longint o [3]);
        longint unsigned mag [3];
        longint unsigned m;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        m = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            o[i] = 0;
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) return 1'b0;
        while (m >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            m = m >> 1;
        end
        while (m < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            m = m << 1;
        end
        for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 30) + (len >> 1)) / len;
            o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic wide_t round_q30(input wide_t v);
        logic [69:0] m;
        m = v < 0 ? -v : v;
        m = (m + (70'd1 << 29)) >> 30;
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic coord_t eye_offset(input longint r [3], input longint e [3]);
        wide_t acc;
        wide_t t;
        acc = 0;
        for (int i = 0; i < 3; i++) acc = acc + wide_t'(r[i]) * wide_t'(e[i]);
        t = -round_q30(acc);
        if (t > 70'sd2147483647) return 32'sh7fff_ffff;
        if (t < -70'sd2147483648) return 32'sh8000_0000;
        return coord_t'(t[31:0]);
    endfunction

    task automatic predict_view(input coord_t ex, ey, ez, tx, ty, tz);
        longint eye [3];
        longint dir [3];
        longint f [3];
        longint sv [3];
        longint s [3];
        longint u [3];
        longint nf [3];
        coord_t tr [3];
        bit degen;
        view_row_t r;
        eye[0] = ex;
        eye[1] = ey;
        eye[2] = ez;
        dir[0] = longint'(tx) - eye[0];
        dir[1] = longint'(ty) - eye[1];
        dir[2] = longint'(tz) - eye[2];
        s = '{0, 0, 0};
        u = '{0, 0, 0};
        degen = !unit_vec(dir, f);
        if (!degen) begin
            sv[0] = f[1];
            sv[1] = -f[0];
            sv[2] = 0;
            degen = !unit_vec(sv, s);
        end
        if (!degen) begin
            u[0] = longint'(round_q30(wide_t'(s[1] * f[2]) - wide_t'(s[2] * f[1])));
            u[1] = longint'(round_q30(wide_t'(s[2] * f[0]) - wide_t'(s[0] * f[2])));
            u[2] = longint'(round_q30(wide_t'(s[0] * f[1]) - wide_t'(s[1] * f[0])));
        end
        for (int i = 0; i < 3; i++) nf[i] = -f[i];
        tr[0] = eye_offset(s, eye);
        tr[1] = eye_offset(u, eye);
        tr[2] = eye_offset(nf, eye);
        for (int k = 0; k < 4; k++) begin
            r = '0;
            r.idx = row_t'(k);
            r.last = (k == 3);
            r.degen = degen;
            if (!degen) begin
                case (k)
                    0: begin
                        r.a = coord_t'(s[0]);
                        r.b = coord_t'(s[1]);
                        r.c = coord_t'(s[2]);
                        r.d = tr[0];
                    end
                    1: begin
                        r.a = coord_t'(u[0]);
                        r.b = coord_t'(u[1]);
                        r.c = coord_t'(u[2]);
                        r.d = tr[1];
                    end
                    2: begin
                        r.a = coord_t'(nf[0]);
                        r.b = coord_t'(nf[1]);
                        r.c = coord_t'(nf[2]);
                        r.d = tr[2];
                    end
                    default: r.d = Q16One;
                endcase
            end
            rows_due.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t: row mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        view_row_t want;
        if (!aresetn) begin
            mismatches = 0;
        end else begin
            if (s_valid && s_ready)
                predict_view(s_eye_x, s_eye_y, s_eye_z, s_target_x, s_target_y, s_target_z);
            if (m_valid && m_ready) begin
                if (rows_due.size() == 0) begin
                    report_mismatch("unexpected row");
                end else begin
                    want = rows_due.pop_front();
                    if (m_row_index !== want.idx || m_col_a !== want.a || m_col_b !== want.b ||
                        m_col_c !== want.c || m_col_d !== want.d ||
                        m_degenerate !== want.degen || m_last_row !== want.last)
                        report_mismatch($sformatf(
                            "got %0d %h %h %h %h %b %b want %0d %h %h %h %h %b %b",
                            m_row_index, m_col_a, m_col_b, m_col_c, m_col_d,
                            m_degenerate, m_last_row, want.idx, want.a, want.b,
                            want.c, want.d, want.degen, want.last));
                end
            end
        end
        rows_pending = rows_due.size();
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import lav_pkg::*;

    logic   aclk;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    coord_t s_eye_x, s_eye_y, s_eye_z;
    coord_t s_target_x, s_target_y, s_target_z;
    logic   m_valid;
    logic   m_ready;
    row_t   m_row_index;
    coord_t m_col_a, m_col_b, m_col_c, m_col_d;
    logic   m_degenerate;
    logic   m_last_row;
    int     mismatches;
    int     rows_pending;
    int     send_idle;
    int     recv_stall;

    look_at_view_matrix dut (.*);

    lav_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_points(input coord_t ex, ey, ez, tx, ty, tz);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_eye_x    <= ex;
        s_eye_y    <= ey;
        s_eye_z    <= ez;
        s_target_x <= tx;
        s_target_y <= ty;
        s_target_z <= tz;
        @(posedge aclk iff (s_valid && s_ready));
    endtask

    function automatic coord_t pick_coord();
        case ($urandom_range(4))
            0: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            1: return coord_t'($signed($urandom_range(2047)) - 1024);
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic send_random();
        coord_t ex, ey, ez, tx, ty, tz;
        ex = pick_coord();
        ey = pick_coord();
        ez = pick_coord();
        tx = pick_coord();
        ty = pick_coord();
        tz = pick_coord();
        case ($urandom_range(19))
            0: begin tx = ex; ty = ey; tz = ez; end
            1: begin tx = ex; ty = ey; end
            2: begin tx = ex + coord_t'($urandom_range(3)); ty = ey; end
            default: ;
        endcase
        send_points(ex, ey, ez, tx, ty, tz);
    endtask

    localparam coord_t MaxC = 32'sh7fff_ffff;
    localparam coord_t MinC = 32'sh8000_0000;

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_eye_x    = '0;
        s_eye_y    = '0;
        s_eye_z    = '0;
        s_target_x = '0;
        s_target_y = '0;
        s_target_z = '0;
        send_idle  = 28;
        recv_stall = 82;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_points(0, 0, 0, 0, 0, 0);
        send_points(MaxC, MinC, 5, MaxC, MinC, 5);
        send_points(0, 0, 0, 0, 0, Q16One);
        send_points(7, -3, MaxC, 7, -3, MinC);
        send_points(0, 0, 0, Q16One, 0, 0);
        send_points(0, 0, 0, 0, Q16One, 0);
        send_points(0, 0, 0, 1, 1, 1);
        send_points(MinC, MinC, MinC, MaxC, MaxC, MaxC);
        send_points(MaxC, MaxC, MaxC, MinC, MinC, MinC);
        send_points(MaxC, MinC, MaxC, MinC, MaxC, MinC);
        send_points(MinC, MaxC, 0, MaxC, MinC, 0);
        send_points(MaxC, MaxC, MaxC, 0, 0, 0);
        send_points(MinC, MinC, MinC, 1, 0, 0);
        send_points(-1, -1, -1, 0, 0, 0);
        send_points(32'sh0003_0000, 32'sh0002_0000, 32'sh0001_0000, 0, 0, 0);
        send_points(0, 0, 0, 1, 0, MaxC);
        send_points(MaxC, MaxC, 0, MaxC - 1, MaxC, 0);

        for (int n = 0; n < 260; n++) begin
            if (n == 90) begin
                send_idle  = 82;
                recv_stall = 28;
            end else if (n == 180) begin
                send_idle  = 0;
                recv_stall = 0;
            end
            send_random();
        end
        s_valid <= 1'b0;
        @(posedge aclk);

        wait (rows_pending == 0);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && rows_pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
design/lav_pkg.sv
design/lav_norm.sv
design/look_at_view_matrix.sv
verif/lav_checker.sv
verif/tb_top.sv
